@@ hw/rtl/vrrl_pkg.sv @@
package vrrl_pkg;

  localparam int unsigned BufferBytesDef = 1024;
  localparam int unsigned MaxRecordsDef  = 32;

  // stream payload widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned LenW     = 11;
  localparam int unsigned OffW     = 10;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEWEST_RD,
    ST_NEWEST_GOT,
    ST_FIT,
    ST_WRAP_RD,
    ST_WRAP_CHK,
    ST_OVL_RD,
    ST_OVL_CHK,
    ST_INSERT,
    ST_WRITE,
    ST_QRY,
    ST_QTAB,
    ST_QBYTE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic tab_rd_newest;
    logic tab_rd_oldest;
    logic tab_rd_query;
    logic set_pos;
    logic zero_pos;
    logic dec_total;
    logic insert;
    logic write_byte;
    logic qry_start;
    logic qry_tab;
    logic qry_byte;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic in_start;
    logic total_zero;
    logic pos_over;
    logic wrap_hit;
    logic ovl_hit;
    logic avail;
    logic byte_ok;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/variable_record_ring_log_core.sv @@
// Channel  | Dir | Signals           | Payload
// s_axis   | in  | tvalid/tready     | tuser: mode; tdata: entry fields
// m_axis   | out | tvalid/tready     | tdata: read result
//
// A read of a missing record skips the table and byte reads; a plain byte is
// written, then answered as a query. An entry start inserts at once into an
// empty table; otherwise it reads the newest record, may wrap, and drops each
// overlapped record before the insert. The record table's single registered
// read port paces the drop walk. Reset clears the record count and pointers;
// stores need no clearing. A result waits in the output register, and the next
// item is taken meanwhile but does not finish until it is free.
module variable_record_ring_log_core import vrrl_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef,
  parameter int unsigned MAX_RECORDS  = MaxRecordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [0] entry_start, [11:1] entry_length, [19:12] data_byte,
  // [24:20] record_index, [34:25] char_offset
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] mode
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] read_byte, [8] entry_available, [19:9] entry_length_out,
  // [25:20] entry_count
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cmd_t    cmd;
  status_t status;

  vrrl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  vrrl_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_RECORDS  (MAX_RECORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[25:20]) <= MAX_RECORDS))
    else $error("record count above table size");

  a_unavail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[8]) |->
      (m_axis_tdata_o[19:9] == '0 && m_axis_tdata_o[7:0] == '0))
    else $error("missing record returned data");

  a_tab_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.tab_rd_newest, cmd.tab_rd_oldest, cmd.tab_rd_query}))
    else $error("record table read port conflict");

endmodule

@@ hw/rtl/vrrl_ram.sv @@
module vrrl_ram import vrrl_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/vrrl_ctrl.sv @@
module vrrl_ctrl import vrrl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          if (status_i.in_mode) begin
            state_d = ST_QRY;
          end else if (status_i.in_start) begin
            state_d = status_i.total_zero ? ST_INSERT : ST_NEWEST_RD;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_NEWEST_RD:  state_d = ST_NEWEST_GOT;
      ST_NEWEST_GOT: state_d = ST_FIT;
      ST_FIT:        state_d = status_i.pos_over ? ST_WRAP_RD : ST_OVL_RD;
      ST_WRAP_RD:    state_d = status_i.total_zero ? ST_OVL_RD : ST_WRAP_CHK;
      ST_WRAP_CHK:   state_d = status_i.wrap_hit ? ST_WRAP_RD : ST_OVL_RD;
      ST_OVL_RD:     state_d = status_i.total_zero ? ST_INSERT : ST_OVL_CHK;
      ST_OVL_CHK:    state_d = status_i.ovl_hit ? ST_OVL_RD : ST_INSERT;
      ST_INSERT:     state_d = ST_WRITE;
      ST_WRITE:      state_d = ST_QRY;
      ST_QRY:        state_d = status_i.avail ? ST_QTAB : ST_OUT;
      ST_QTAB:       state_d = status_i.byte_ok ? ST_QBYTE : ST_OUT;
      ST_QBYTE:      state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.accept   = status_i.in_valid;
      end
      ST_NEWEST_RD:  cmd_o.tab_rd_newest = 1'b1;
      ST_NEWEST_GOT: cmd_o.set_pos = 1'b1;
      ST_WRAP_RD: begin
        if (status_i.total_zero) begin
          cmd_o.zero_pos = 1'b1;
        end else begin
          cmd_o.tab_rd_oldest = 1'b1;
        end
      end
      ST_WRAP_CHK: begin
        if (status_i.wrap_hit) begin
          cmd_o.dec_total = 1'b1;
        end else begin
          cmd_o.zero_pos = 1'b1;
        end
      end
      ST_OVL_RD:  cmd_o.tab_rd_oldest = !status_i.total_zero;
      ST_OVL_CHK: cmd_o.dec_total = status_i.ovl_hit;
      ST_INSERT:  cmd_o.insert = 1'b1;
      ST_WRITE:   cmd_o.write_byte = 1'b1;
      ST_QRY: begin
        cmd_o.qry_start    = 1'b1;
        cmd_o.tab_rd_query = 1'b1;
      end
      ST_QTAB:  cmd_o.qry_tab = 1'b1;
      ST_QBYTE: cmd_o.qry_byte = 1'b1;
      ST_OUT:   cmd_o.load_out = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/vrrl_datapath.sv @@
module vrrl_datapath import vrrl_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef,
  parameter int unsigned MAX_RECORDS  = MaxRecordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                in_valid_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_user_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned PW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned XW = PW + 12;
  localparam int unsigned SW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned IW = SW + 2;
  localparam int unsigned TW = 2 * PW;

  // input fields
  logic            in_start;
  logic [LenW-1:0] in_len;
  logic [ByteW-1:0] in_byte;
  logic [IdxW-1:0] in_idx;
  logic [OffW-1:0] in_off;
  logic [PW-1:0]   in_len_sat;

  assign in_start = in_data_i[0];
  assign in_len   = in_data_i[11:1];
  assign in_byte  = in_data_i[19:12];
  assign in_idx   = in_data_i[24:20];
  assign in_off   = in_data_i[34:25];
  assign in_len_sat = (XW'(in_len) > XW'(BUFFER_BYTES)) ? PW'(BUFFER_BYTES) : PW'(in_len);

  logic [PW-1:0]    len_q;
  logic [ByteW-1:0] data_q;
  logic [IdxW-1:0]  idx_q;
  logic [OffW-1:0]  off_q;
  logic [SW-1:0]    newest_q, newest_d;
  logic [CW-1:0]    total_q, total_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [PW-1:0]    wp_q, wp_d;
  logic [PW-1:0]    bl_q, bl_d;
  logic             avail_q;
  logic [PW-1:0]    rlen_q;
  logic [ByteW-1:0] rbyte_q;
  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // record table and byte store
  logic [SW-1:0] tab_raddr;
  logic [TW-1:0] tab_rdata;
  logic [PW-1:0] tab_start, tab_len;
  logic [SW-1:0] newest_next, oldest_slot, qry_slot;
  logic [IW-1:0] old_tmp, qry_tmp;
  logic [PW-1:0] pos_fin;
  logic          byte_we;
  logic [AW-1:0] byte_raddr;
  logic [ByteW-1:0] byte_rdata;
  logic [XW-1:0] rd_addr;

  assign tab_start = tab_rdata[TW-1:PW];
  assign tab_len   = tab_rdata[PW-1:0];

  assign newest_next = (newest_q == SW'(MAX_RECORDS - 1)) ? '0 : newest_q + 1'b1;
  assign old_tmp = IW'(newest_q) + IW'(MAX_RECORDS) + IW'(1) - IW'(total_q);
  assign qry_tmp = IW'(newest_q) + IW'(MAX_RECORDS) - IW'(idx_q);
  assign oldest_slot = (old_tmp >= IW'(MAX_RECORDS)) ? SW'(old_tmp - IW'(MAX_RECORDS))
                                                    : SW'(old_tmp);
  assign qry_slot = (qry_tmp >= IW'(MAX_RECORDS)) ? SW'(qry_tmp - IW'(MAX_RECORDS))
                                                  : SW'(qry_tmp);
  assign pos_fin = (total_q == '0) ? '0 : pos_q;

  always_comb begin
    tab_raddr = newest_q;
    if (cmd_i.tab_rd_oldest) begin
      tab_raddr = oldest_slot;
    end else if (cmd_i.tab_rd_query) begin
      tab_raddr = qry_slot;
    end
  end

  vrrl_ram #(.Width(TW), .Depth(MAX_RECORDS)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (newest_next),
    .wdata_i ({pos_fin, len_q}),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  assign byte_we = cmd_i.write_byte && (bl_q != '0) && (wp_q < PW'(BUFFER_BYTES));
  assign rd_addr = XW'(tab_start) + XW'(off_q);
  assign byte_raddr = rd_addr[AW-1:0];

  vrrl_ram #(.Width(ByteW), .Depth(BUFFER_BYTES)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (wp_q[AW-1:0]),
    .wdata_i (data_q),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  always_comb begin
    newest_d = newest_q;
    total_d  = total_q;
    pos_d    = pos_q;
    wp_d     = wp_q;
    bl_d     = bl_q;
    if (cmd_i.accept && !in_user_i && in_start && (total_q >= CW'(MAX_RECORDS))) begin
      total_d = CW'(MAX_RECORDS - 1);
    end
    if (cmd_i.set_pos) begin
      pos_d = PW'(XW'(tab_start) + XW'(tab_len));
    end
    if (cmd_i.zero_pos) begin
      pos_d = '0;
    end
    if (cmd_i.dec_total) begin
      total_d = total_q - 1'b1;
    end
    if (cmd_i.insert) begin
      newest_d = newest_next;
      total_d  = total_q + 1'b1;
      wp_d     = pos_fin;
      bl_d     = len_q;
    end
    if (cmd_i.write_byte && (bl_q != '0)) begin
      wp_d = wp_q + 1'b1;
      bl_d = bl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q    <= '0;
      total_q     <= '0;
      wp_q        <= '0;
      bl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      newest_q <= newest_d;
      total_q  <= total_d;
      wp_q     <= wp_d;
      bl_q     <= bl_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.accept) begin
      len_q  <= in_len_sat;
      data_q <= in_byte;
      idx_q  <= in_idx;
      off_q  <= in_off;
    end
    if (cmd_i.qry_start) begin
      avail_q <= status_o.avail;
      rlen_q  <= '0;
      rbyte_q <= '0;
    end
    if (cmd_i.qry_tab) begin
      rlen_q <= tab_len;
    end
    if (cmd_i.qry_byte) begin
      rbyte_q <= byte_rdata;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {6'd0, CountW'(total_q), LenW'(rlen_q), avail_q, rbyte_q};
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.in_valid   = in_valid_i;
    status_o.in_mode    = in_user_i;
    status_o.in_start   = in_start;
    status_o.total_zero = (total_q == '0);
    status_o.pos_over   = (XW'(pos_q) + XW'(len_q)) > XW'(BUFFER_BYTES);
    status_o.wrap_hit   = tab_start >= pos_q;
    status_o.ovl_hit    = (tab_start >= pos_q) &&
                          (XW'(tab_start) < (XW'(pos_q) + XW'(len_q)));
    status_o.avail      = 16'(idx_q) < 16'(total_q);
    status_o.byte_ok    = (XW'(off_q) < XW'(tab_len)) && (rd_addr < XW'(BUFFER_BYTES));
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
